// File: rtl/pci_pkg.sv
// Shared widths, register map and saturating fixed-point helpers for the PID block.
package pci_pkg;

  localparam int DW     = 32;          // data word
  localparam int FB     = 16;          // fraction bits
  localparam int AW     = DW + 3;      // exact width for short sums
  localparam int PW     = 2 * DW;      // full product / wide magnitude
  localparam int NW     = DW + FB;     // divider numerator and quotient
  localparam int CNT_W  = $clog2(NW + 1);
  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_GAIN_P  = 3'd0;
  localparam logic [2:0] REG_GAIN_I  = 3'd1;
  localparam logic [2:0] REG_GAIN_D  = 3'd2;
  localparam logic [2:0] REG_LOW     = 3'd3;
  localparam logic [2:0] REG_HIGH    = 3'd4;
  localparam logic [2:0] REG_MODE    = 3'd5;

  localparam logic [DW-1:0] W_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] W_MIN = {1'b1, {(DW-1){1'b0}}};

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    mag = v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  // signed word from sign and wide magnitude, saturated
  function automatic logic [DW-1:0] sat_mag(input logic neg, input logic [PW-1:0] m);
    logic [PW-1:0] lim;
    lim = {{(PW-DW){1'b0}}, W_MAX};
    if (neg) begin
      sat_mag = (m > lim) ? W_MIN : (~m[DW-1:0] + 1'b1);
    end else begin
      sat_mag = (m > lim) ? W_MAX : m[DW-1:0];
    end
  endfunction

  function automatic logic signed [AW-1:0] ext(input logic [DW-1:0] v);
    ext = $signed({{(AW-DW){v[DW-1]}}, v});
  endfunction

  function automatic logic [DW-1:0] sat_w(input logic signed [AW-1:0] v);
    if (v > ext(W_MAX)) begin
      sat_w = W_MAX;
    end else if (v < ext(W_MIN)) begin
      sat_w = W_MIN;
    end else begin
      sat_w = v[DW-1:0];
    end
  endfunction

  function automatic logic [DW-1:0] clampv(input logic [DW-1:0] v, input logic [DW-1:0] lo,
                                           input logic [DW-1:0] hi);
    if ($signed(v) > $signed(hi)) begin
      clampv = hi;
    end else if ($signed(v) < $signed(lo)) begin
      clampv = lo;
    end else begin
      clampv = v;
    end
  endfunction

endpackage

// File: rtl/pci_mul.sv
// Bit-serial signed Q multiplier: shift-add over the magnitudes, floor shift, saturate.
module pci_mul import pci_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  output logic          done_o,
  output logic [DW-1:0] p_o
);

  logic [DW-1:0]    x_q, hi_q, lo_q;
  logic             neg_q, busy_q, fin_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW:0]      sum;
  logic [PW-1:0]    shifted, rounded;

  assign sum     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, x_q} : '0);
  assign shifted = {hi_q, lo_q} >> FB;
  assign rounded = shifted + {{(PW-1){1'b0}}, (neg_q && (|lo_q[FB-1:0]))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      hi_q   <= '0;
      lo_q   <= '0;
      neg_q  <= 1'b0;
      p_o    <= '0;
    end else begin
      done_o <= 1'b0;
      fin_q  <= 1'b0;
      if (go_i) begin
        x_q    <= mag(a_i);
        lo_q   <= mag(b_i);
        hi_q   <= '0;
        neg_q  <= a_i[DW-1] ^ b_i[DW-1];
        cnt_q  <= CNT_W'(DW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        hi_q  <= sum[DW:1];
        lo_q  <= {sum[0], lo_q[DW-1:1]};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        p_o    <= sat_mag(neg_q, rounded);
        done_o <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/pci_div.sv
// Bit-serial restoring divider: (a << FB) / d truncated toward zero, saturated.
module pci_div import pci_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] d_i,
  output logic          done_o,
  output logic [DW-1:0] q_o
);

  logic [NW-1:0]    n_q;
  logic [DW-1:0]    dv_q, rem_q;
  logic             neg_q, busy_q, fin_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW:0]      r2, diff;
  logic             ge;

  assign r2   = {rem_q, n_q[NW-1]};
  assign ge   = r2 >= {1'b0, dv_q};
  assign diff = r2 - {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
      n_q    <= '0;
      dv_q   <= '0;
      rem_q  <= '0;
      neg_q  <= 1'b0;
      q_o    <= '0;
    end else begin
      done_o <= 1'b0;
      fin_q  <= 1'b0;
      if (go_i) begin
        n_q    <= {mag(a_i), {FB{1'b0}}};
        dv_q   <= mag(d_i);
        rem_q  <= '0;
        neg_q  <= a_i[DW-1] ^ d_i[DW-1];
        cnt_q  <= CNT_W'(NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DW-1:0] : r2[DW-1:0];
        n_q   <= {n_q[NW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        q_o    <= sat_mag(neg_q, {{(PW-NW){1'b0}}, n_q});
        done_o <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/pid_controller_pos_inc.sv
// PID controller top level: APB registers, step sequencer, output register.
// A clear goes straight to the output register; a step forms the error and then three
// products, and a positional step with nonzero gain_i first divides both limits by it.
// Throughput: one transaction at a time, set by the bit-serial multiplier (three products)
// and divider (two bounds). The next transaction can be taken in the cycle after the result
// loads, even while that result waits.
// Reset (rst_ni low, async): gains 0, limits full range, positional mode, state zero.
module pid_controller_pos_inc import pci_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB config
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [2*DW-1:0]   s_axis_tdata,   // [DW-1:0] setpoint, [2DW-1:DW] measured
  input  logic              s_axis_tuser,   // [0] op: 0 step, 1 clear
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DW-1:0]     m_axis_tdata    // [DW-1:0] drive
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ERR   = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_DIVLO = 3'd3;
  localparam logic [2:0] S_DIVHI = 3'd4;
  localparam logic [2:0] S_CLAMP = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // config registers
  logic [DW-1:0] gain_p_q, gain_i_q, gain_d_q, low_q, high_q;
  logic          mode_q;
  logic          cfg_wr;
  logic [2:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    case (cfg_idx)
      REG_GAIN_P: prdata = gain_p_q;
      REG_GAIN_I: prdata = gain_i_q;
      REG_GAIN_D: prdata = gain_d_q;
      REG_LOW:    prdata = low_q;
      REG_HIGH:   prdata = high_q;
      REG_MODE:   prdata = {31'd0, mode_q};
      default:    prdata = '0;
    endcase
  end

  // datapath state
  logic [2:0]    state_q;
  logic [1:0]    term_q;
  logic [DW-1:0] sp_q, ms_q, e_q, b0_q, b2_q, blo_q, bhi_q;
  logic [DW-1:0] isum_q, last_q, prev_q, out_q;
  logic          op_q, out_valid_q, mul_go_q, div_go_q;
  logic signed [AW-1:0] acc_q;

  // ordered output limits
  logic [DW-1:0] lim_lo, lim_hi;
  assign lim_lo = ($signed(low_q) > $signed(high_q)) ? high_q : low_q;
  assign lim_hi = ($signed(low_q) > $signed(high_q)) ? low_q : high_q;

  logic [DW-1:0] mul_a, mul_b, mul_p, div_q, drive;
  logic          mul_done, div_done, out_load;

  always_comb begin
    case (term_q)
      2'd0:    begin mul_a = gain_p_q; mul_b = b0_q; end
      2'd1:    begin mul_a = gain_i_q; mul_b = mode_q ? e_q : isum_q; end
      default: begin mul_a = gain_d_q; mul_b = b2_q; end
    endcase
  end

  pci_mul u_mul (
    .clk_i, .rst_ni, .go_i(mul_go_q), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  pci_div u_div (
    .clk_i, .rst_ni, .go_i(div_go_q),
    .a_i(state_q == S_DIVLO ? lim_lo : lim_hi), .d_i(gain_i_q),
    .done_o(div_done), .q_o(div_q)
  );

  // integral bounds in order (negative gain swaps them)
  logic [DW-1:0] ib_lo, ib_hi;
  assign ib_lo = ($signed(blo_q) > $signed(bhi_q)) ? bhi_q : blo_q;
  assign ib_hi = ($signed(blo_q) > $signed(bhi_q)) ? blo_q : bhi_q;

  assign drive         = op_q ? '0 : clampv(sat_w(acc_q), lim_lo, lim_hi);
  assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      low_q       <= W_MIN;
      high_q      <= W_MAX;
      mode_q      <= 1'b0;
      state_q     <= S_IDLE;
      term_q      <= '0;
      sp_q        <= '0;
      ms_q        <= '0;
      op_q        <= 1'b0;
      e_q         <= '0;
      b0_q        <= '0;
      b2_q        <= '0;
      blo_q       <= '0;
      bhi_q       <= '0;
      isum_q      <= '0;
      last_q      <= '0;
      prev_q      <= '0;
      acc_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
    end else begin
      mul_go_q <= 1'b0;
      div_go_q <= 1'b0;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_GAIN_P: gain_p_q <= pwdata[DW-1:0];
          REG_GAIN_I: gain_i_q <= pwdata[DW-1:0];
          REG_GAIN_D: gain_d_q <= pwdata[DW-1:0];
          REG_LOW:    low_q    <= pwdata[DW-1:0];
          REG_HIGH:   high_q   <= pwdata[DW-1:0];
          REG_MODE:   mode_q   <= pwdata[0];
          default:    ;
        endcase
      end
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            sp_q    <= s_axis_tdata[DW-1:0];
            ms_q    <= s_axis_tdata[2*DW-1:DW];
            op_q    <= s_axis_tuser;
            state_q <= s_axis_tuser ? S_OUT : S_ERR;
          end
        end
        S_ERR: begin
          e_q     <= sat_w(ext(sp_q) - ext(ms_q));
          state_q <= S_PREP;
        end
        S_PREP: begin
          acc_q  <= '0;
          term_q <= 2'd0;
          if (mode_q) begin
            b0_q     <= sat_w(ext(e_q) - ext(last_q));
            b2_q     <= sat_w(ext(e_q) - (ext(last_q) <<< 1) + ext(prev_q));
            mul_go_q <= 1'b1;
            state_q  <= S_MUL;
          end else begin
            b0_q <= e_q;
            b2_q <= sat_w(ext(e_q) - ext(last_q));
            if (gain_i_q == '0) begin
              isum_q   <= '0;
              mul_go_q <= 1'b1;
              state_q  <= S_MUL;
            end else begin
              isum_q   <= sat_w(ext(isum_q) + ext(e_q));
              div_go_q <= 1'b1;
              state_q  <= S_DIVLO;
            end
          end
        end
        S_DIVLO: begin
          if (div_done) begin
            blo_q    <= div_q;
            div_go_q <= 1'b1;
            state_q  <= S_DIVHI;
          end
        end
        S_DIVHI: begin
          if (div_done) begin
            bhi_q   <= div_q;
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          isum_q   <= clampv(isum_q, ib_lo, ib_hi);
          mul_go_q <= 1'b1;
          state_q  <= S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            acc_q <= acc_q + ext(mul_p);
            if (term_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              term_q   <= term_q + 1'b1;
              mul_go_q <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_q       <= drive;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (op_q) begin
              isum_q <= '0;
              last_q <= '0;
              prev_q <= '0;
            end else begin
              prev_q <= last_q;
              last_q <= e_q;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // a clear transaction leaves all loop state at zero
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && op_q |=> isum_q == '0 && last_q == '0 && prev_q == '0)
    else $error("clear did not zero loop state");

  // every loaded step result lies within the ordered limits (a clear gives zero)
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !op_q |=> $signed(out_q) >= $signed(lim_lo) && $signed(out_q) <= $signed(lim_hi))
    else $error("drive outside limits");

  // checks that the divider is never started on a zero integral gain
  a_div_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_go_q |-> gain_i_q != '0)
    else $error("divide by zero gain");

  // products only come back while the sequencer waits for them
  a_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_MUL)
    else $error("stray multiplier result");

endmodule
